// ===== sv/crc16fr_pkg.sv =====
// crc16fr_pkg: result kind codes and CRC-16/MODBUS constants for the frame receiver.
// No dependencies; used by the result channel interface, the receiver unit and the testbench.
`default_nettype none

package crc16fr_pkg;

  typedef enum logic [1:0] {
    KIND_WORD    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

endpackage

`default_nettype wire

// ===== sv/crc16fr_if.sv =====
// crc16fr_if: valid/ready channel interfaces for received bytes and for results.
// Depends on crc16fr_pkg for the result kind type.
`default_nettype none

interface crc16fr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc16fr_result_if;
  crc16fr_pkg::kind_t kind;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_address;
  logic [7:0]         frame_command;
  logic [3:0]         word_index;
  logic [15:0]        word_value;
  logic [4:0]         word_count;
  logic               last;

  modport source (output valid, output kind, output frame_address, output frame_command,
                  output word_index, output word_value, output word_count, output last,
                  input ready);
  modport sink   (input valid, input kind, input frame_address, input frame_command,
                  input word_index, input word_value, input word_count, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/crc16_frame_receiver_unit.sv =====
// crc16_frame_receiver_unit: framed packet receiver with CRC-16/MODBUS check.
// Depends on crc16fr_pkg and the channel interfaces in crc16fr_if.sv.
`default_nettype none

// Receives one byte per transaction on in_if. Bytes are dropped until one
// equals the start marker (cfg_wr_data, written with cfg_wr_en); then come
// address, command, data byte count, the data bytes (paired into
// little-endian words) and the received CRC, low byte first. The CRC
// (init 0xFFFF, reflected poly 0xA001, no final xor) covers address through
// last data byte. A good frame yields one result per word (last flagged on
// the final one), or one empty-frame result when the count is zero; a CRC
// mismatch gives one error result, an odd count or one above 2*MAX_WORDS
// gives one bad-length result as soon as the count byte arrives.
// Timing: the CRC is run by one shared shift/xor unit, one bit per cycle,
// so a byte covered by the CRC (address, command, count, data) occupies the
// receiver for its transaction plus 8 CRC steps; marker hunting and the
// CRC bytes take only the transaction. A single result waits for a free
// output register; a good frame drains word by word, each through a
// registered read of the word store, then the output register, held while
// the sink stalls. The output register lets a finished result wait while
// the next byte is taken in. The word store needs no clearing after reset.
module crc16_frame_receiver_unit #(
  parameter int MAX_WORDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  crc16fr_byte_if.sink     in_if,
  crc16fr_result_if.source out_if
);
  import crc16fr_pkg::*;

  // Store address width, byte counter width (holds 2*MAX_WORDS), word count width
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(2 * MAX_WORDS + 1);
  localparam int NW = $clog2(MAX_WORDS + 1);
  localparam logic [8:0] MAX_LEN = 9'(2 * MAX_WORDS);

  // Sequencer
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CRC    = 5'b00010,
    ST_SINGLE = 5'b00100,
    ST_READ   = 5'b01000,
    ST_WORD   = 5'b10000
  } seq_t;

  // Position within the frame
  typedef enum logic [6:0] {
    PH_HUNT  = 7'b0000001,
    PH_ADDR  = 7'b0000010,
    PH_CMD   = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CRCLO = 7'b0100000,
    PH_CRCHI = 7'b1000000
  } phase_t;

  seq_t          seq_r, seq_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    marker_r;
  logic [15:0]   crc_r, crc_nxt;
  logic [2:0]    bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0] byte_cnt_r, byte_cnt_nxt;
  kind_t         single_kind_r, single_kind_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  // Frame payload holds
  logic [7:0]    addr_r, cmd_r, len_r, low_r, crc_low_r;
  logic [15:0]   rd_data_r;
  logic [15:0]   mem [MAX_WORDS];

  // Output register
  logic          out_valid_r;
  kind_t         out_kind_r;
  logic [7:0]    out_addr_r, out_cmd_r;
  logic [3:0]    out_idx_r;
  logic [15:0]   out_value_r;
  logic [4:0]    out_count_r;
  logic          out_last_r;

  logic          in_acc, out_free, load_single, load_word;
  logic [7:0]    b;
  logic [CW-1:0] byte_cnt_inc;
  logic          len_bad;
  logic [15:0]   rx_crc;

  assign in_if.ready = (seq_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign b           = in_if.rx_byte;
  assign out_free    = !out_valid_r || out_if.ready;
  assign load_single = (seq_r == ST_SINGLE) && out_free;
  assign load_word   = (seq_r == ST_WORD) && out_free;

  assign byte_cnt_inc = byte_cnt_r + CW'(1);
  assign len_bad      = b[0] || ({1'b0, b} > MAX_LEN);
  assign rx_crc       = {b, crc_low_r};

  always_comb begin
    seq_nxt         = seq_r;
    phase_nxt       = phase_r;
    crc_nxt         = crc_r;
    bit_cnt_nxt     = bit_cnt_r;
    byte_cnt_nxt    = byte_cnt_r;
    single_kind_nxt = single_kind_r;
    rd_idx_nxt      = rd_idx_r;
    cnt_nxt         = cnt_r;
    unique case (seq_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (phase_r)
            PH_HUNT: begin
              if (b == marker_r) begin
                crc_nxt      = CRC_INIT;
                byte_cnt_nxt = '0;
                phase_nxt    = PH_ADDR;
              end
            end
            PH_ADDR: begin
              crc_nxt   = crc_r ^ {8'h00, b};
              seq_nxt   = ST_CRC;
              phase_nxt = PH_CMD;
            end
            PH_CMD: begin
              crc_nxt   = crc_r ^ {8'h00, b};
              seq_nxt   = ST_CRC;
              phase_nxt = PH_LEN;
            end
            PH_LEN: begin
              byte_cnt_nxt = '0;
              if (len_bad) begin
                // no CRC needed: the next hunt reloads it
                single_kind_nxt = KIND_BAD_LEN;
                seq_nxt         = ST_SINGLE;
                phase_nxt       = PH_HUNT;
              end else begin
                crc_nxt   = crc_r ^ {8'h00, b};
                seq_nxt   = ST_CRC;
                phase_nxt = (b == 8'h00) ? PH_CRCLO : PH_DATA;
              end
            end
            PH_DATA: begin
              crc_nxt      = crc_r ^ {8'h00, b};
              seq_nxt      = ST_CRC;
              byte_cnt_nxt = byte_cnt_inc;
              if (9'(byte_cnt_inc) >= {1'b0, len_r}) begin
                phase_nxt = PH_CRCLO;
              end
            end
            PH_CRCLO: begin
              phase_nxt = PH_CRCHI;
            end
            PH_CRCHI: begin
              phase_nxt = PH_HUNT;
              if (rx_crc != crc_r) begin
                single_kind_nxt = KIND_CRC_ERR;
                seq_nxt         = ST_SINGLE;
              end else if (len_r == 8'h00) begin
                single_kind_nxt = KIND_EMPTY;
                seq_nxt         = ST_SINGLE;
              end else begin
                cnt_nxt    = NW'(len_r >> 1);
                rd_idx_nxt = '0;
                seq_nxt    = ST_READ;
              end
            end
            default: phase_nxt = PH_HUNT;
          endcase
        end
      end
      ST_CRC: begin
        // one bit of the reflected CRC per cycle
        crc_nxt     = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        if (bit_cnt_r == 3'd7) begin
          seq_nxt = ST_IDLE;
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          seq_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        seq_nxt = ST_WORD;
      end
      ST_WORD: begin
        if (out_free) begin
          if (NW'(rd_idx_r) + NW'(1) == cnt_r) begin
            seq_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
            seq_nxt    = ST_READ;
          end
        end
      end
      default: seq_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r         <= ST_IDLE;
      phase_r       <= PH_HUNT;
      marker_r      <= 8'h00;
      crc_r         <= CRC_INIT;
      bit_cnt_r     <= '0;
      byte_cnt_r    <= '0;
      single_kind_r <= KIND_EMPTY;
      rd_idx_r      <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      seq_r         <= seq_nxt;
      phase_r       <= phase_nxt;
      crc_r         <= crc_nxt;
      bit_cnt_r     <= bit_cnt_nxt;
      byte_cnt_r    <= byte_cnt_nxt;
      single_kind_r <= single_kind_nxt;
      rd_idx_r      <= rd_idx_nxt;
      cnt_r         <= cnt_nxt;
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
      if (load_single || load_word) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame holds and word store
  always_ff @(posedge clk) begin
    if (in_acc) begin
      unique case (phase_r)
        PH_ADDR:  addr_r    <= b;
        PH_CMD:   cmd_r     <= b;
        PH_LEN:   len_r     <= b;
        PH_CRCLO: crc_low_r <= b;
        PH_DATA: begin
          if (!byte_cnt_r[0]) begin
            low_r <= b;
          end else begin
            mem[byte_cnt_r[AW:1]] <= {b, low_r};
          end
        end
        default: ;
      endcase
    end
    if (seq_r == ST_READ) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_single) begin
      out_kind_r  <= single_kind_r;
      out_addr_r  <= addr_r;
      out_cmd_r   <= cmd_r;
      out_idx_r   <= 4'd0;
      out_value_r <= 16'h0000;
      out_count_r <= 5'd0;
      out_last_r  <= 1'b1;
    end else if (load_word) begin
      out_kind_r  <= KIND_WORD;
      out_addr_r  <= addr_r;
      out_cmd_r   <= cmd_r;
      out_idx_r   <= 4'(rd_idx_r);
      out_value_r <= rd_data_r;
      out_count_r <= 5'(cnt_r);
      out_last_r  <= (NW'(rd_idx_r) + NW'(1) == cnt_r);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_kind_r;
  assign out_if.frame_address = out_addr_r;
  assign out_if.frame_command = out_cmd_r;
  assign out_if.word_index    = out_idx_r;
  assign out_if.word_value    = out_value_r;
  assign out_if.word_count    = out_count_r;
  assign out_if.last          = out_last_r;

endmodule

`default_nettype wire

// ===== dv/crc16_frame_receiver_unit_tb.sv =====
// Self-checking testbench for crc16_frame_receiver_unit: framed byte stream in, word results out.
// Depends on crc16fr_pkg, the channel interfaces in crc16fr_if.sv and the unit itself.
// A predictor in this module follows every accepted byte; results are checked in order.
module crc16_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16fr_pkg::*;

  localparam int MAX_WORDS     = 16;
  localparam int RESET_CYCLES  = 9;
  // Settle time covers the CRC steps of a CRC-covered byte and a lone result.
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 200;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASE_ITEMS   = 42;   // bytes the parser acts on per random phase; four random phases

  // Receive phases of the frame parser, as the predictor tracks them.
  typedef enum logic [2:0] {
    RX_HUNT, RX_ADDR, RX_CMD, RX_LEN, RX_DATA, RX_CRC_LO, RX_CRC_HI
  } rx_phase_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [3:0]  index;
    logic [15:0] value;
    logic [4:0]  count;
    logic        last;
  } frame_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  crc16fr_byte_if   rx_ch ();
  crc16fr_result_if res_ch ();

  crc16_frame_receiver_unit #(
    .MAX_WORDS(MAX_WORDS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_if      (rx_ch),
    .out_if     (res_ch)
  );

  // Predictor state: a copy of the parser's registers and the start marker.
  rx_phase_t   rx_phase        = RX_HUNT;
  logic [7:0]  marker_reg      = 8'h00;
  logic [7:0]  held_address    = 8'h00;
  logic [7:0]  held_command    = 8'h00;
  logic [7:0]  held_length     = 8'h00;
  logic [7:0]  data_byte_count = 8'h00;
  logic [15:0] crc_acc         = CRC_INIT;
  logic [7:0]  data_low_byte   = 8'h00;
  logic [7:0]  crc_low_byte    = 8'h00;
  logic [15:0] word_mem [MAX_WORDS];

  frame_result_t pending_results[$];   // results owed by the unit, oldest first
  logic [7:0]    tx_bytes[$];          // link bytes waiting to be sent

  int  error_count   = 0;
  int  cycle_count   = 0;
  int  decoded_items = 0;   // bytes the parser acts on (hunting misses excluded)
  bit  no_idle       = 0;   // both sides run flat out while set
  bit  long_hold_req = 0;
  bit  hold_active   = 0;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] ERROR run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    return crc;
  endfunction

  function automatic void push_result(kind_t kind, logic [3:0] index, logic [15:0] value,
                                      logic [4:0] count, logic last);
    frame_result_t r;
    r.kind    = kind;
    r.address = held_address;
    r.command = held_command;
    r.index   = index;
    r.value   = value;
    r.count   = count;
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  // Advances the parser copy by one accepted byte and queues what it owes.
  function automatic void decode_byte(logic [7:0] b);
    int          words;
    logic [15:0] rx_crc;
    if (rx_phase != RX_HUNT || b == marker_reg)
      decoded_items++;
    unique case (rx_phase)
      RX_HUNT: begin
        // marker only counts while hunting; inside a frame it is plain data
        if (b == marker_reg) begin
          crc_acc         = CRC_INIT;
          data_byte_count = 8'h00;
          rx_phase        = RX_ADDR;
        end
      end
      RX_ADDR: begin
        held_address = b;
        crc_acc      = crc16_step(crc_acc, b);
        rx_phase     = RX_CMD;
      end
      RX_CMD: begin
        held_command = b;
        crc_acc      = crc16_step(crc_acc, b);
        rx_phase     = RX_LEN;
      end
      RX_LEN: begin
        held_length     = b;
        crc_acc         = crc16_step(crc_acc, b);
        data_byte_count = 8'h00;
        // odd or oversized count: reject at once, no data or CRC taken
        if (b[0] || b > 2 * MAX_WORDS) begin
          push_result(KIND_BAD_LEN, 4'd0, 16'h0000, 5'd0, 1'b1);
          rx_phase = RX_HUNT;
        end else if (b == 8'h00) begin
          rx_phase = RX_CRC_LO;
        end else begin
          rx_phase = RX_DATA;
        end
      end
      RX_DATA: begin
        crc_acc = crc16_step(crc_acc, b);
        if (!data_byte_count[0])
          data_low_byte = b;
        else
          word_mem[data_byte_count[4:1]] = {b, data_low_byte};
        data_byte_count++;
        if (data_byte_count >= held_length)
          rx_phase = RX_CRC_LO;
      end
      RX_CRC_LO: begin
        crc_low_byte = b;
        rx_phase     = RX_CRC_HI;
      end
      RX_CRC_HI: begin
        rx_crc = {b, crc_low_byte};
        if (rx_crc != crc_acc) begin
          push_result(KIND_CRC_ERR, 4'd0, 16'h0000, 5'd0, 1'b1);
        end else if (held_length == 8'h00) begin
          push_result(KIND_EMPTY, 4'd0, 16'h0000, 5'd0, 1'b1);
        end else begin
          words = held_length / 2;
          for (int i = 0; i < words; i++)
            push_result(KIND_WORD, 4'(i), word_mem[i], 5'(words), i == words - 1);
        end
        rx_phase = RX_HUNT;
      end
      default: rx_phase = RX_HUNT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    error_count++;
    $display("[%0t] ERROR %s", $time, msg);
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d addr=%h cmd=%h idx=%0d",
                                  res_ch.kind, res_ch.frame_address, res_ch.frame_command,
                                  res_ch.word_index));
      end else begin
        want = pending_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.frame_address !== want.address ||
            res_ch.frame_command !== want.command || res_ch.word_index !== want.index ||
            res_ch.word_value !== want.value || res_ch.word_count !== want.count ||
            res_ch.last !== want.last)
          report_mismatch($sformatf(
            "got kind=%0d a=%h c=%h i=%0d v=%h n=%0d l=%0d, want %0d %h %h %0d %h %0d %0d",
            res_ch.kind, res_ch.frame_address, res_ch.frame_command, res_ch.word_index,
            res_ch.word_value, res_ch.word_count, res_ch.last, want.kind, want.address,
            want.command, want.index, want.value, want.count, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, plus one long hold on request
  // ---------------------------------------------------------------------------
  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    int n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // held off long enough for the output register and the input to back up
        hold_active = 1;
        res_ch.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
        long_hold_req = 0;
        hold_active   = 0;
      end else if (no_idle) begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          res_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source and frame building
  // ---------------------------------------------------------------------------
  // Offers one byte and waits for its transaction; valid is left high so a
  // following byte can go out back to back.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    decode_byte(b);
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0)
      send_byte(tx_bytes.pop_front());
  endtask

  // Drops valid, waits for every owed result, then lets the unit settle.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_marker(logic [7:0] m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    marker_reg = m;
  endtask

  // Appends one frame to tx_bytes. Bad counts carry only the header; a
  // truncated frame stops somewhere in its data and has no CRC.
  function automatic void queue_frame(logic [7:0] mk, logic [7:0] addr, logic [7:0] cmd,
                                      logic [7:0] len, bit crc_ok, bit mk_in_data,
                                      bit truncate);
    logic [15:0] crc;
    logic [7:0]  d;
    int          n;
    tx_bytes.push_back(mk);
    tx_bytes.push_back(addr);
    tx_bytes.push_back(cmd);
    tx_bytes.push_back(len);
    crc = crc16_step(crc16_step(crc16_step(CRC_INIT, addr), cmd), len);
    if (len[0] || len > 2 * MAX_WORDS)
      return;
    n = (truncate && len > 0) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < n; i++) begin
      d = (mk_in_data && $urandom_range(0, 3) == 0) ? mk : 8'($urandom);
      tx_bytes.push_back(d);
      crc = crc16_step(crc, d);
    end
    if (truncate)
      return;
    if (!crc_ok)
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    tx_bytes.push_back(crc[7:0]);
    tx_bytes.push_back(crc[15:8]);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every result kind under the reset marker of zero, field extremes included.
  task automatic test_frame_kinds();
    tx_bytes.push_back(8'h55);                                   // ignored while hunting
    tx_bytes.push_back(8'hFF);
    queue_frame(8'h00, 8'hFF, 8'h00, 8'd0,   1, 0, 0);           // empty good frame
    queue_frame(8'h00, 8'h00, 8'hFF, 8'd1,   1, 0, 0);           // odd count
    queue_frame(8'h00, 8'h12, 8'h34, 8'd34,  1, 0, 0);           // one word too many
    queue_frame(8'h00, 8'h56, 8'h78, 8'd255, 1, 0, 0);           // largest count
    queue_frame(8'h00, 8'hA5, 8'h5A, 8'd2,   0, 0, 0);           // CRC mismatch
    queue_frame(8'h00, 8'h01, 8'h03, 8'd2,   1, 1, 0);           // single good word
    send_queued();
  endtask

  // Marker value inside a frame is data; a new marker waits for the next hunt.
  task automatic test_marker_handling();
    set_marker(8'hFF);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 8'd8, 1, 1, 0);
    send_queued();
    // stop after the count and two data bytes, change marker, then finish the frame
    queue_frame(8'hFF, 8'h33, 8'h44, 8'd4, 1, 0, 0);
    for (int i = 0; i < 6; i++)
      send_byte(tx_bytes.pop_front());
    set_marker(8'h3C);
    send_queued();
    tx_bytes.push_back(8'hFF);                                   // old marker is noise now
    queue_frame(8'h3C, 8'h3C, 8'h3C, 8'd6, 1, 1, 0);
    send_queued();
  endtask

  // Two full frames at full input rate while the sink is held off.
  task automatic test_full_frame_pressure();
    logic [7:0] mk;
    mk = 8'($urandom);
    set_marker(mk);
    long_hold_req = 1;
    while (!hold_active) @(posedge clk);
    no_idle = 1;
    queue_frame(mk, 8'($urandom), 8'($urandom), 8'd32, 1, 1, 0);
    queue_frame(mk, 8'($urandom), 8'($urandom), 8'd32, 1, 0, 0);
    send_queued();
    no_idle = 0;
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, plus errors, broken frames
  // and line noise, over several marker settings.
  task automatic test_random_traffic();
    logic [7:0] markers[4];
    logic [7:0] mk;
    logic [7:0] len;
    int         r;
    markers[0] = 8'h00;
    markers[1] = 8'hFF;
    markers[2] = 8'($urandom);
    markers[3] = 8'($urandom);
    for (int p = 0; p < 4; p++) begin
      mk = markers[p];
      set_marker(mk);
      decoded_items = 0;
      while (decoded_items < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 5) == 0);
        // mostly short frames, the odd long one
        len = ($urandom_range(0, 9) == 0) ? 8'(2 * $urandom_range(9, 16))
                                          : 8'(2 * $urandom_range(0, 4));
        r = $urandom_range(0, 99);
        if (r < 60) begin
          queue_frame(mk, 8'($urandom), 8'($urandom), len, 1, $urandom_range(0, 1), 0);
        end else if (r < 70) begin
          queue_frame(mk, 8'($urandom), 8'($urandom), len, 0, 0, 0);
        end else if (r < 80) begin
          len = 8'($urandom);
          if (!len[0] && len <= 2 * MAX_WORDS)
            len[0] = 1'b1;
          queue_frame(mk, 8'($urandom), 8'($urandom), len, 1, 0, 0);
        end else if (r < 88) begin
          queue_frame(mk, 8'($urandom), 8'($urandom), len | 8'd2, 1, 0, 1);
        end else begin
          repeat ($urandom_range(1, 5)) tx_bytes.push_back(8'($urandom));
        end
        send_queued();
      end
    end
    no_idle = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 8'h00;
    rst_n         <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_frame_kinds();
    test_marker_handling();
    test_full_frame_pressure();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/crc16fr_pkg.sv
sv/crc16fr_if.sv
sv/crc16_frame_receiver_unit.sv
dv/crc16_frame_receiver_unit_tb.sv
